[design/gds_pkg.sv]
// ----------------------------------------------------------------------------
// gds_pkg
// Shared widths, unit codes and controller/datapath interface types for the
// Gregorian date subtract unit.
// ----------------------------------------------------------------------------
package gds_pkg;

	localparam int FuncW  = 3;
	localparam int CountW = 15;
	localparam int DayW   = 5;
	localparam int MonthW = 4;
	localparam int YearW  = 16;
	localparam int RemW   = CountW + 3;

	localparam int InDataW  = 40;
	localparam int OutDataW = 32;

	localparam logic [FuncW-1:0] FUNC_DAY    = 3'd0;
	localparam logic [FuncW-1:0] FUNC_WEEK   = 3'd1;
	localparam logic [FuncW-1:0] FUNC_MONTH  = 3'd2;
	localparam logic [FuncW-1:0] FUNC_YEAR   = 3'd3;
	localparam logic [FuncW-1:0] FUNC_DECADE = 3'd4;
	localparam logic [FuncW-1:0] FUNC_CENT   = 3'd5;
	localparam logic [FuncW-1:0] FUNC_MILL   = 3'd6;
	localparam logic [FuncW-1:0] FUNC_NONE   = 3'd7;

	typedef struct packed {
		logic load;
		logic chk;
		logic day_step;
		logic unit_step;
		logic clamp;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic done;
		logic day_unit;
	} sts_t;

endpackage

[design/gds_dpath.sv]
// ----------------------------------------------------------------------------
// gds_dpath
// Date registers, remaining-count register, leap and month-length logic and
// the result register of the Gregorian date subtract unit.
// ----------------------------------------------------------------------------
module gds_dpath (
	input  logic                              clk,
	input  gds_pkg::cmd_t                     cmd,
	output gds_pkg::sts_t                     sts,
	input  logic [gds_pkg::FuncW-1:0]         func,
	input  logic [gds_pkg::CountW-1:0]        count,
	input  logic [gds_pkg::DayW-1:0]          day,
	input  logic [gds_pkg::MonthW-1:0]        month,
	input  logic signed [gds_pkg::YearW-1:0]  year,
	output logic [gds_pkg::DayW-1:0]          out_day,
	output logic [gds_pkg::MonthW-1:0]        out_month,
	output logic signed [gds_pkg::YearW-1:0]  out_year,
	output logic                              bad_date
);

	localparam logic [gds_pkg::DayW-1:0] MonthLen [16] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
	};

	logic [gds_pkg::FuncW-1:0]        func_q;
	logic [gds_pkg::RemW-1:0]         rem_q;
	logic [gds_pkg::DayW-1:0]         day_q;
	logic [gds_pkg::MonthW-1:0]       month_q;
	logic signed [gds_pkg::YearW-1:0] year_q;
	logic                             bad_q;

	logic [gds_pkg::MonthW-1:0]       month_prev;
	logic [gds_pkg::DayW-1:0]         len_cur;
	logic [gds_pkg::DayW-1:0]         len_prev;
	logic                             valid_date;
	logic [gds_pkg::YearW-1:0]        year_dec;
	logic [gds_pkg::RemW-1:0]         count7;

	// divisibility by 25 of |y| through a reciprocal multiply and one correction
	function automatic logic is_leap(input logic signed [gds_pkg::YearW-1:0] y);
		logic [16:0] a;
		logic [28:0] p;
		logic [12:0] q;
		logic [16:0] r;
		logic        by25;
		a    = y[15] ? (17'd0 - {1'b1, y}) : {1'b0, y};
		p    = {12'd0, a} * 29'd2621;
		q    = p[28:16];
		r    = a - ({4'd0, q} * 17'd25);
		by25 = (r == 17'd0) || (r == 17'd25);
		return (y[1:0] == 2'd0) && (!by25 || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [gds_pkg::DayW-1:0] days_in(
		input logic signed [gds_pkg::YearW-1:0] y,
		input logic [gds_pkg::MonthW-1:0]       m
	);
		logic [gds_pkg::DayW-1:0] len;
		if (m == 4'd2) begin
			len = is_leap(y) ? 5'd29 : 5'd28;
		end else begin
			len = MonthLen[m];
		end
		return len;
	endfunction

	assign month_prev = month_q - 4'd1;
	assign len_cur    = days_in(year_q, month_q);
	assign len_prev   = days_in(year_q, month_prev);
	assign valid_date = (month_q >= 4'd1) && (month_q <= 4'd12) &&
	                    (day_q != 5'd0) && (day_q <= len_cur);
	assign count7     = {count, 3'b000} - {3'b000, count};

	always_comb begin
		case (func_q)
			gds_pkg::FUNC_YEAR:   year_dec = 16'd1;
			gds_pkg::FUNC_DECADE: year_dec = 16'd10;
			gds_pkg::FUNC_CENT:   year_dec = 16'd100;
			gds_pkg::FUNC_MILL:   year_dec = 16'd1000;
			default:              year_dec = 16'd0;
		endcase
	end

	assign sts.bad      = !valid_date;
	assign sts.done     = (rem_q == '0) || (func_q == gds_pkg::FUNC_NONE);
	assign sts.day_unit = (func_q == gds_pkg::FUNC_DAY) || (func_q == gds_pkg::FUNC_WEEK);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			rem_q   <= (func == gds_pkg::FUNC_WEEK) ? count7 : {3'b000, count};
			day_q   <= day;
			month_q <= month;
			year_q  <= year;
		end else if (cmd.day_step) begin
			if (rem_q < {13'd0, day_q}) begin
				day_q <= day_q - rem_q[gds_pkg::DayW-1:0];
				rem_q <= '0;
			end else begin
				rem_q <= rem_q - {13'd0, day_q};
				if (month_q == 4'd1) begin
					day_q   <= 5'd31;
					month_q <= 4'd12;
					year_q  <= year_q - 16'sd1;
				end else begin
					day_q   <= len_prev;
					month_q <= month_prev;
				end
			end
		end else if (cmd.unit_step) begin
			rem_q <= rem_q - {{(gds_pkg::RemW-1){1'b0}}, 1'b1};
			if (func_q == gds_pkg::FUNC_MONTH) begin
				if (month_q == 4'd1) begin
					month_q <= 4'd12;
					year_q  <= year_q - 16'sd1;
				end else begin
					month_q <= month_prev;
				end
			end else begin
				year_q <= year_q - $signed(year_dec);
			end
		end else if (cmd.clamp) begin
			if (day_q > len_cur) begin
				day_q <= len_cur;
			end
		end
		if (cmd.chk) begin
			bad_q <= !valid_date;
		end
		if (cmd.emit) begin
			out_day   <= day_q;
			out_month <= month_q;
			out_year  <= year_q;
			bad_date  <= bad_q;
		end
	end

endmodule

[design/gds_ctrl.sv]
// ----------------------------------------------------------------------------
// gds_ctrl
// Controller state machine: sequences validity check, day jumps or unit
// steps with day clamp, and hands the finished date to the output register.
// ----------------------------------------------------------------------------
module gds_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output gds_pkg::cmd_t cmd,
	input  gds_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DAY,
		ST_STEP,
		ST_FIX,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && s_tvalid;
		cmd.chk       = (state_q == ST_CHECK);
		cmd.day_step  = (state_q == ST_DAY) && !sts.done;
		cmd.unit_step = (state_q == ST_STEP);
		cmd.clamp     = (state_q == ST_FIX);
		cmd.emit      = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (sts.bad || sts.done) begin
						state_q <= ST_DONE;
					end else if (sts.day_unit) begin
						state_q <= ST_DAY;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_DAY: begin
					if (sts.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_STEP: begin
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (sts.done) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_DONE: begin
					if (cmd.emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/gregorian_date_subtract_unit.sv]
// ----------------------------------------------------------------------------
// gregorian_date_subtract_unit
// Moves a Gregorian date back by a count of days, weeks, months, years,
// decades, centuries or millennia; invalid dates pass through flagged.
//
// Channel  Dir  Transaction contents
// s_*      in   tuser: func; tdata: count, day, month, year
// m_*      out  tuser: bad_date; tdata: out_day, out_month, out_year
//
// Steps: accept, check, emit; day and week units add a day jump per month
//   crossed, one jump for a part-month remainder and a final pass to finish;
//   month and year-based units add a unit step, then a day clamp, per count.
// One transaction in work at a time; a new one is taken while a finished
//   result waits in the output register.
// Reset clears the controller and the output valid; payload is not reset.
// ----------------------------------------------------------------------------
module gregorian_date_subtract_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [gds_pkg::InDataW-1:0]   s_tdata,  // count, day, month, year
	input  logic [gds_pkg::FuncW-1:0]     s_tuser,  // func
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [gds_pkg::OutDataW-1:0]  m_tdata,  // out_day, out_month, out_year
	output logic                          m_tuser   // bad_date
);

	gds_pkg::cmd_t                    cmd;
	gds_pkg::sts_t                    sts;
	logic [gds_pkg::DayW-1:0]         out_day;
	logic [gds_pkg::MonthW-1:0]       out_month;
	logic signed [gds_pkg::YearW-1:0] out_year;

	gds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	gds_dpath u_dpath (
		.clk       (clk),
		.cmd       (cmd),
		.sts       (sts),
		.func      (s_tuser),
		.count     (s_tdata[14:0]),
		.day       (s_tdata[19:15]),
		.month     (s_tdata[23:20]),
		.year      (s_tdata[39:24]),
		.out_day   (out_day),
		.out_month (out_month),
		.out_year  (out_year),
		.bad_date  (m_tuser)
	);

	assign m_tdata = {7'd0, out_year, out_month, out_day};

endmodule

[design/gds_checker.sv]
// ----------------------------------------------------------------------------
// gds_checker
// Port-level checks of the Gregorian date subtract unit: output hold under
// stall, sane dates on good results, and one result per transaction.
// ----------------------------------------------------------------------------
module gds_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [gds_pkg::OutDataW-1:0] m_tdata,
	input logic                         m_tuser
);

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_good_date: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[8:5] >= 4'd1) && (m_tdata[8:5] <= 4'd12) &&
		(m_tdata[4:0] != 5'd0))
		else $error("good result carries an impossible date");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 2'd0)
		else $error("result without a transaction");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> pending_q <= 2'd1)
		else $error("transaction taken with work and output both full");

endmodule

bind gregorian_date_subtract_unit gds_checker u_gds_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams dates through the date subtract unit and checks every result
// against an in-bench calendar predictor. A directed set covers the unit
// codes, the count extremes, leap days, year wrap, the unused unit code and
// malformed dates. Random traffic follows under several idle and stall mixes,
// with one long output hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic [gds_pkg::FuncW-1:0]  func;
		logic [gds_pkg::CountW-1:0] count;
		logic [gds_pkg::DayW-1:0]   day;
		logic [gds_pkg::MonthW-1:0] month;
		logic [gds_pkg::YearW-1:0]  year;
	} date_req_t;

	typedef struct packed {
		logic [gds_pkg::DayW-1:0]   day;
		logic [gds_pkg::MonthW-1:0] month;
		logic [gds_pkg::YearW-1:0]  year;
		logic                       bad;
	} date_res_t;

	class date_scoreboard;
		date_res_t owed_dates[$];
		int        mismatches;

		static function int month_days(int y, int m);
			case (m)
				2: return ((y % 400 == 0) || (y % 4 == 0 && y % 100 != 0)) ? 29 : 28;
				4, 6, 9, 11: return 30;
				1, 3, 5, 7, 8, 10, 12: return 31;
				default: return 0;
			endcase
		endfunction

		static function date_res_t date_back(date_req_t r);
			date_res_t                        res;
			int                               d, m, lim, steps;
			logic signed [gds_pkg::YearW-1:0] y, stride;
			d      = int'(r.day);
			m      = int'(r.month);
			y      = r.year;
			steps  = int'(r.count);
			stride = 16'sd1;
			res.bad = 1'b0;
			if (m < 1 || m > 12 || d < 1 || d > month_days(int'(y), m)) begin
				res.bad = 1'b1;
			end else begin
				case (r.func)
					gds_pkg::FUNC_DAY, gds_pkg::FUNC_WEEK: begin
						if (r.func == gds_pkg::FUNC_WEEK)
							steps = steps * 7;
						repeat (steps) begin
							if (d > 1) begin
								d = d - 1;
							end else if (m == 1) begin
								d = 31;
								m = 12;
								y = y - 16'sd1;
							end else begin
								m = m - 1;
								d = month_days(int'(y), m);
							end
						end
					end
					gds_pkg::FUNC_MONTH: begin
						repeat (steps) begin
							if (m == 1) begin
								m = 12;
								y = y - 16'sd1;
							end else begin
								m = m - 1;
							end
							lim = month_days(int'(y), m);
							if (d > lim)
								d = lim;
						end
					end
					gds_pkg::FUNC_YEAR, gds_pkg::FUNC_DECADE, gds_pkg::FUNC_CENT,
					gds_pkg::FUNC_MILL: begin
						case (r.func)
							gds_pkg::FUNC_DECADE: stride = 16'sd10;
							gds_pkg::FUNC_CENT:   stride = 16'sd100;
							gds_pkg::FUNC_MILL:   stride = 16'sd1000;
							default:              stride = 16'sd1;
						endcase
						repeat (steps) begin
							y   = y - stride;
							lim = month_days(int'(y), m);
							if (d > lim)
								d = lim;
						end
					end
					default: ;
				endcase
			end
			res.day   = d[gds_pkg::DayW-1:0];
			res.month = m[gds_pkg::MonthW-1:0];
			res.year  = y;
			return res;
		endfunction

		function void note_request(date_req_t r);
			owed_dates.push_back(date_back(r));
		endfunction

		function void check_result(logic [gds_pkg::OutDataW-1:0] data, logic flag);
			date_res_t want;
			date_res_t got;
			got.day   = data[gds_pkg::DayW-1:0];
			got.month = data[gds_pkg::DayW+gds_pkg::MonthW-1:gds_pkg::DayW];
			got.year  = data[gds_pkg::DayW+gds_pkg::MonthW+gds_pkg::YearW-1:
				gds_pkg::DayW+gds_pkg::MonthW];
			got.bad   = flag;
			if (owed_dates.size() == 0) begin
				$display("%0t: unexpected result day %0d month %0d year %0d bad %0b",
					$time, got.day, got.month, $signed(got.year), got.bad);
				mismatches++;
				return;
			end
			want = owed_dates.pop_front();
			if (got.day !== want.day) begin
				$display("%0t: out_day expected %0d actual %0d", $time, want.day, got.day);
				mismatches++;
			end
			if (got.month !== want.month) begin
				$display("%0t: out_month expected %0d actual %0d", $time, want.month,
					got.month);
				mismatches++;
			end
			if (got.year !== want.year) begin
				$display("%0t: out_year expected %0d actual %0d", $time,
					$signed(want.year), $signed(got.year));
				mismatches++;
			end
			if (got.bad !== want.bad) begin
				$display("%0t: bad_date expected %0b actual %0b", $time, want.bad, got.bad);
				mismatches++;
			end
		endfunction
	endclass

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [gds_pkg::InDataW-1:0]   s_tdata  = '0;
	logic [gds_pkg::FuncW-1:0]     s_tuser  = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [gds_pkg::OutDataW-1:0]  m_tdata;
	logic                          m_tuser;

	date_scoreboard ledger;
	int             idle_pct    = 0;
	int             stall_pct   = 0;
	int             hold_cycles = 0;

	gregorian_date_subtract_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			ledger.check_result(m_tdata, m_tuser);
		if (hold_cycles > 0) begin
			m_tready    <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= (int'($urandom_range(99)) >= stall_pct);
		end
	end

	function automatic date_req_t mk(logic [gds_pkg::FuncW-1:0] f, int cnt, int d, int m,
		int y);
		date_req_t r;
		r.func  = f;
		r.count = cnt[gds_pkg::CountW-1:0];
		r.day   = d[gds_pkg::DayW-1:0];
		r.month = m[gds_pkg::MonthW-1:0];
		r.year  = y[gds_pkg::YearW-1:0];
		return r;
	endfunction

	function automatic date_req_t rand_date();
		date_req_t   r;
		int          yr, len, pick;
		bit          valid;
		logic [31:0] rnd;
		rnd    = $urandom_range(7);
		r.func = rnd[gds_pkg::FuncW-1:0];
		pick   = int'($urandom_range(99));
		if (pick < 12) begin
			rnd     = $urandom;
			r.day   = rnd[gds_pkg::DayW-1:0];
			rnd     = $urandom;
			r.month = rnd[gds_pkg::MonthW-1:0];
			rnd     = $urandom;
			r.year  = rnd[gds_pkg::YearW-1:0];
		end else begin
			case ($urandom_range(3))
				0: yr = 32767 - int'($urandom_range(40));
				1: yr = int'($urandom_range(40)) - 32768;
				2: yr = int'($urandom_range(3000)) - 1000;
				default: yr = int'($urandom);
			endcase
			r.year  = yr[gds_pkg::YearW-1:0];
			rnd     = $urandom_range(12, 1);
			r.month = rnd[gds_pkg::MonthW-1:0];
			len     = date_scoreboard::month_days(int'($signed(r.year)), int'(r.month));
			case ($urandom_range(5))
				0: r.day = len[gds_pkg::DayW-1:0];
				1: r.day = 5'd1;
				default: begin
					rnd   = $urandom_range(len, 1);
					r.day = rnd[gds_pkg::DayW-1:0];
				end
			endcase
		end
		valid = (r.month >= 1 && r.month <= 12 && r.day >= 1 &&
			int'(r.day) <= date_scoreboard::month_days(int'($signed(r.year)),
			int'(r.month)));
		pick = int'($urandom_range(99));
		if (!valid || r.func == gds_pkg::FUNC_NONE)
			rnd = $urandom;
		else if (pick < 60)
			rnd = $urandom_range(15);
		else if (pick < 95)
			rnd = $urandom_range(255);
		else
			rnd = $urandom_range(2047);
		r.count = rnd[gds_pkg::CountW-1:0];
		return r;
	endfunction

	task automatic offer(date_req_t r);
		s_tuser  <= r.func;
		s_tdata  <= {r.year, r.month, r.day, r.count};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		ledger.note_request(r);
		while (int'($urandom_range(99)) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic offer_random(int n);
		repeat (n) offer(rand_date());
	endtask

	initial begin
		ledger = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(mk(gds_pkg::FUNC_DAY,    0,     15, 6,  2023));
		offer(mk(gds_pkg::FUNC_DAY,    1,     1,  1,  -32768));
		offer(mk(gds_pkg::FUNC_DAY,    1,     1,  3,  2024));
		offer(mk(gds_pkg::FUNC_DAY,    1,     1,  3,  1900));
		offer(mk(gds_pkg::FUNC_DAY,    365,   31, 12, 2000));
		offer(mk(gds_pkg::FUNC_DAY,    60,    29, 2,  -4));
		offer(mk(gds_pkg::FUNC_WEEK,   32767, 31, 12, 32767));
		offer(mk(gds_pkg::FUNC_MONTH,  1,     31, 3,  2023));
		offer(mk(gds_pkg::FUNC_MONTH,  32767, 31, 1,  0));
		offer(mk(gds_pkg::FUNC_YEAR,   1,     29, 2,  2024));
		offer(mk(gds_pkg::FUNC_YEAR,   4,     29, 2,  -400));
		offer(mk(gds_pkg::FUNC_DECADE, 4,     29, 2,  2000));
		offer(mk(gds_pkg::FUNC_CENT,   4,     29, 2,  2000));
		offer(mk(gds_pkg::FUNC_MILL,   1,     1,  1,  -32768));
		offer(mk(gds_pkg::FUNC_MILL,   32767, 29, 2,  0));
		offer(mk(gds_pkg::FUNC_NONE,   32767, 10, 10, 10));
		offer(mk(gds_pkg::FUNC_DAY,    5,     1,  0,  2020));
		offer(mk(gds_pkg::FUNC_MONTH,  5,     12, 13, 2020));
		offer(mk(gds_pkg::FUNC_YEAR,   32767, 31, 15, -1));
		offer(mk(gds_pkg::FUNC_WEEK,   3,     0,  5,  2020));
		offer(mk(gds_pkg::FUNC_DAY,    3,     31, 4,  2020));
		offer(mk(gds_pkg::FUNC_YEAR,   1,     29, 2,  1900));
		offer(mk(gds_pkg::FUNC_CENT,   1,     29, 2,  -100));

		offer_random(440);

		// back up the unit behind a long output hold
		hold_cycles <= 400;
		offer_random(30);

		idle_pct  = 82;
		offer_random(440);
		idle_pct  = 0;
		stall_pct <= 82;
		offer_random(440);
		idle_pct  = 14;
		stall_pct <= 14;
		offer_random(430);

		s_tvalid  <= 1'b0;
		stall_pct <= 0;
		while (ledger.owed_dates.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (ledger.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
